/* rtl/apr_pkg.sv */
// ----------------------------------------------------------------------------
// apr_pkg: shared types and constants
// Frame table geometry, configuration register map and the sequencer states
// of the aging page replacement core.
// ----------------------------------------------------------------------------
`default_nettype none
package apr_pkg;

  localparam int FRAMES = 256;
  localparam int SLOT_W = $clog2(FRAMES);
  localparam int CNT_W  = $clog2(FRAMES + 1);
  localparam int PAGE_W = 20;
  localparam int AGE_W  = 16;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [4:0]       RST_COUNTER_BITS  = 5'd8;
  localparam logic [15:0]      RST_AGING_PERIOD  = 16'd0;
  localparam logic [CNT_W-1:0] RST_FRAMES_IN_USE = CNT_W'(FRAMES);

  typedef enum logic [1:0] {
    REG_COUNTER_BITS  = 2'd0,
    REG_AGING_PERIOD  = 2'd1,
    REG_FRAMES_IN_USE = 2'd2,
    REG_NONE          = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [4:0]       counter_bits;
    logic [15:0]      aging_period;
    logic [CNT_W-1:0] frames_in_use;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // Counter width clamped to 1..16
  function automatic logic [4:0] clamp_width(input logic [4:0] cb);
    logic [4:0] w;
    w = cb;
    if (w < 5'd1) w = 5'd1;
    if (w > 5'd16) w = 5'd16;
    return w;
  endfunction

  function automatic logic [AGE_W-1:0] top_bit(input logic [4:0] cb);
    logic [4:0] w;
    w = clamp_width(cb);
    return AGE_W'(1) << (w - 5'd1);
  endfunction

  function automatic logic [AGE_W-1:0] age_mask(input logic [4:0] cb);
    logic [4:0] w;
    w = clamp_width(cb);
    if (w >= 5'd16) return {AGE_W{1'b1}};
    return (AGE_W'(1) << w) - AGE_W'(1);
  endfunction

  function automatic logic [CNT_W-1:0] usable_frames(input logic [CNT_W-1:0] fiu);
    logic [CNT_W-1:0] n;
    n = fiu;
    if (n < CNT_W'(1)) n = CNT_W'(1);
    if (n > CNT_W'(FRAMES)) n = CNT_W'(FRAMES);
    return n;
  endfunction

endpackage
`default_nettype wire

/* rtl/aging_page_replacement_core.sv */
// ----------------------------------------------------------------------------
// aging_page_replacement_core: aging page replacement engine
// Frame table with per-slot aging counters, swept by one sequencer.
// ----------------------------------------------------------------------------
// Usage: raise start with page_number while busy is low; the request is taken
// at that edge. Each request yields one result, shown for exactly one cycle
// with done high: hit, fault, slot, evicted_page and fault_count. The receiver
// cannot stall; results are never held.
// The very first request after reset only fills slot 0: done follows in the
// next cycle and busy stays low. Every later request sweeps the filled slots
// through the single read port of the frame table, one slot per cycle,
// aging, matching and tracking the lowest counter in the same pass; after the
// drain state, the finish state writes the new page on a miss. Busy covers the
// sweep, drain and finish states, and done rises with busy falling.
// Registers (APB, pready always high): counter_bits at 0x0, aging_period at
// 0x4, frames_in_use at 0x8. Write them only while busy is low.
// Reset clears the fill count, the aging count and the fault count and loads
// the register defaults; the table needs no clearing since only filled slots
// are ever read.
// ----------------------------------------------------------------------------
`default_nettype none
module aging_page_replacement_core
  import apr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [PAGE_W-1:0] page_number,
  output logic                   done,
  output logic                   hit,
  output logic                   fault,
  output logic [7:0]             slot,
  output logic [PAGE_W-1:0]      evicted_page,
  output logic [31:0]            fault_count,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  cfg_t cfg;

  apr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Frame table: page number over aging counter
  logic [PAGE_W+AGE_W-1:0] table_mem [FRAMES];
  logic [PAGE_W+AGE_W-1:0] rd_word;

  state_t state, state_next;

  logic [CNT_W-1:0]  filled;
  logic [15:0]       refs;
  logic [31:0]       faults;
  logic [CNT_W-1:0]  idx;
  logic              rv;
  logic [SLOT_W-1:0] ra;
  logic [PAGE_W-1:0] page_q;
  logic              age_now;
  logic              found;
  logic [SLOT_W-1:0] hit_slot;
  logic [AGE_W-1:0]  low;
  logic [SLOT_W-1:0] best;
  logic [PAGE_W-1:0] best_page;

  logic [AGE_W-1:0]  top, mask;
  logic [CNT_W-1:0]  n, live;
  logic              accept, first_ref, rd_en, fin, can_fill;
  logic [PAGE_W-1:0] rpage;
  logic [AGE_W-1:0]  rage, aged, hit_val;
  logic              in_live, match;
  logic              we;
  logic [SLOT_W-1:0] waddr;
  logic [PAGE_W+AGE_W-1:0] wdata;
  logic [15:0]       refs_base;

  assign top       = top_bit(cfg.counter_bits);
  assign mask      = age_mask(cfg.counter_bits);
  assign n         = usable_frames(cfg.frames_in_use);
  assign live      = (filled < n) ? filled : n;
  assign can_fill  = filled < n;
  assign accept    = start && !busy;
  assign first_ref = filled == '0;

  assign rpage   = rd_word[PAGE_W+AGE_W-1:AGE_W];
  assign rage    = rd_word[AGE_W-1:0];
  assign aged    = age_now ? (rage >> 1) : rage;
  assign hit_val = ((aged >> 1) | top) & mask;
  assign in_live = {1'b0, ra} < live;
  assign match   = rv && in_live && !found && (rpage == page_q);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (accept && !first_ref) state_next = ST_SCAN;
      ST_SCAN:   if (idx == filled - CNT_W'(1)) state_next = ST_DRAIN;
      ST_DRAIN:  state_next = ST_FINISH;
      ST_FINISH: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    busy  = 1'b1;
    rd_en = 1'b0;
    fin   = 1'b0;
    case (state)
      ST_IDLE:   busy = 1'b0;
      ST_SCAN:   rd_en = 1'b1;
      ST_DRAIN:  ;
      ST_FINISH: fin = 1'b1;
      default:   ;
    endcase
  end

  // Single write port: first fill, sweep write-back, or final placement
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = {rpage, aged};
    if (accept && first_ref) begin
      we    = 1'b1;
      wdata = {page_number, top};
    end else if (rv) begin
      we    = age_now || match;
      waddr = ra;
      wdata = match ? {rpage, hit_val} : {rpage, aged};
    end else if (fin && !found) begin
      we    = 1'b1;
      waddr = can_fill ? filled[SLOT_W-1:0] : best;
      wdata = {page_q, top};
    end
  end

  always_ff @(posedge clk) begin
    if (we) table_mem[waddr] <= wdata;
    if (rd_en) rd_word <= table_mem[idx[SLOT_W-1:0]];
  end

  assign refs_base = age_now ? 16'd0 : refs;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      filled <= '0;
      refs   <= '0;
      faults <= '0;
      rv     <= 1'b0;
      done   <= 1'b0;
    end else begin
      state <= state_next;
      rv    <= rd_en;
      done  <= 1'b0;
      if (accept && first_ref) begin
        filled <= CNT_W'(1);
        done   <= 1'b1;
      end
      if (fin) begin
        done <= 1'b1;
        if (!found && can_fill) filled <= filled + CNT_W'(1);
        if (!found && !can_fill && faults != 32'hFFFF_FFFF) faults <= faults + 32'd1;
        if (cfg.aging_period != 16'd0 && refs_base < 16'hFFFF) begin
          refs <= refs_base + 16'd1;
        end else if (age_now) begin
          refs <= 16'd0;
        end
      end
    end
  end

  // Sweep datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      page_q  <= page_number;
      age_now <= (cfg.aging_period == 16'd0) || (refs >= cfg.aging_period);
      found   <= 1'b0;
      idx     <= '0;
    end
    if (rd_en) begin
      ra  <= idx[SLOT_W-1:0];
      idx <= idx + CNT_W'(1);
    end
    if (match) begin
      found    <= 1'b1;
      hit_slot <= ra;
    end
    // Strict compare keeps the earliest slot on ties
    if (rv && in_live && (ra == '0 || aged < low)) begin
      low       <= aged;
      best      <= ra;
      best_page <= rpage;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (accept && first_ref) begin
      hit          <= 1'b0;
      fault        <= 1'b0;
      slot         <= 8'd0;
      evicted_page <= '0;
      fault_count  <= faults;
    end else if (fin) begin
      hit          <= found;
      fault        <= !found && !can_fill;
      evicted_page <= (!found && !can_fill) ? best_page : '0;
      if (found) begin
        slot <= 8'(hit_slot);
      end else if (can_fill) begin
        slot <= 8'(filled[SLOT_W-1:0]);
      end else begin
        slot <= 8'(best);
      end
      if (!found && !can_fill && faults != 32'hFFFF_FFFF) begin
        fault_count <= faults + 32'd1;
      end else begin
        fault_count <= faults;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/apr_regs.sv */
// ----------------------------------------------------------------------------
// apr_regs: configuration register file
// APB-style slave holding counter width, aging period and frame count.
// ----------------------------------------------------------------------------
`default_nettype none
module apr_regs
  import apr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.counter_bits  <= RST_COUNTER_BITS;
      cfg.aging_period  <= RST_AGING_PERIOD;
      cfg.frames_in_use <= RST_FRAMES_IN_USE;
    end else if (wr) begin
      case (idx)
        REG_COUNTER_BITS:  cfg.counter_bits  <= pwdata[4:0];
        REG_AGING_PERIOD:  cfg.aging_period  <= pwdata[15:0];
        REG_FRAMES_IN_USE: cfg.frames_in_use <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_COUNTER_BITS:  prdata = DATA_W'(cfg.counter_bits);
      REG_AGING_PERIOD:  prdata = DATA_W'(cfg.aging_period);
      REG_FRAMES_IN_USE: prdata = DATA_W'(cfg.frames_in_use);
      default:           prdata = '0;
    endcase
  end

endmodule
`default_nettype wire
